@@ rtl/core/assert_macros.svh @@
// assertion helpers included by the core top-level file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with async reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/wsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and fixed point constants of the water sensor alarm core.
// ----------------------------------------------------------------------------
package wsa_pkg;

	localparam int ADC_BITS  = 10;
	localparam int FRAC_BITS = 8;
	localparam int V_W       = 11;
	localparam int SUM_W     = 32;
	localparam int OUT_W     = 24;
	localparam int TEMP_W    = 16;
	localparam int CNT_W     = 8;
	localparam int CFG_W     = 14;
	localparam int CFG_AW    = 3;
	localparam int DEN_W     = 16;
	localparam int ACC_W     = 40;
	localparam int Q_DEPTH   = 2;
	localparam int Q_CW      = 2;

	localparam logic [CNT_W-1:0] PH_CNT_RST    = 8'd100;
	localparam logic [CNT_W-1:0] OTHER_CNT_RST = 8'd5;
	localparam logic [12:0]      PH_LOW_RST    = 13'd1664;
	localparam logic [12:0]      PH_HIGH_RST   = 13'd2176;
	localparam logic [13:0]      TDS_LIM_RST   = 14'd1000;
	localparam logic [11:0]      TURB_LIM_RST  = 12'd10;

	localparam logic signed [31:0] K_5_7    = 32'sd1459;
	localparam logic signed [31:0] K_21_34  = 32'sd5463;
	localparam logic signed [31:0] K_0_02   = 32'sd5;
	localparam logic signed [31:0] K_133_42 = 32'sd34156;
	localparam logic signed [31:0] K_255_86 = 32'sd65500;
	localparam logic signed [31:0] K_857_39 = 32'sd219492;
	localparam logic signed [31:0] K_1120_4 = 32'sd286822;
	localparam logic signed [31:0] K_5742_3 = 32'sd1470029;
	localparam logic signed [31:0] K_4352_9 = 32'sd1114342;
	localparam logic [V_W-1:0]     V_4_2    = 11'd1075;
	localparam logic [V_W-1:0]     V_2_5    = 11'd640;
	localparam logic signed [31:0] K_3000   = 32'sd768000;
	localparam logic signed [31:0] K_25     = 32'sd6400;
	localparam logic signed [31:0] K_ONE    = 32'sd256;

	localparam logic [CFG_AW-1:0] REG_PH_CNT    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_OTHER_CNT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_PH_LOW    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_PH_HIGH   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_TDS_LIM   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_TURB_LIM  = 3'd5;

	typedef enum logic [1:0] {
		CH_TEMP = 2'd0,
		CH_PH   = 2'd1,
		CH_TDS  = 2'd2,
		CH_TURB = 2'd3
	} chan_t;

	typedef struct packed {
		chan_t          ch;
		logic [V_W-1:0] v;
		logic           turb_zero;
		logic           turb_full;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] ph_cnt;
		logic [CNT_W-1:0] other_cnt;
		logic [12:0]      ph_low;
		logic [12:0]      ph_high;
		logic [13:0]      tds_lim;
		logic [11:0]      turb_lim;
	} cfg_t;

	typedef struct packed {
		logic [Q_CW-1:0] count;
		logic            empty;
		logic            full;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_CONV,
		ST_DIVW,
		ST_ACC,
		ST_AVGW,
		ST_FIN
	} bk_state_t;

	typedef enum logic [2:0] {
		D_V2,
		D_V3,
		D_ADD,
		D_SUB,
		D_CF
	} mul_dest_t;

endpackage

@@ rtl/core/wsa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_front
// Input stage: scales the sample to a voltage and classifies turbidity range.
// ----------------------------------------------------------------------------
module wsa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  wsa_pkg::chan_t        func,
	input  logic [9:0]            sample_code,
	output logic                  item_valid,
	input  logic                  item_ready,
	output wsa_pkg::item_t        item
);
	import wsa_pkg::*;

	localparam int SH = ADC_BITS - FRAC_BITS;

	logic [12:0] prod;
	logic [V_W-1:0] v;
	item_t item_s1;
	logic valid_s1;

	assign prod = {3'b000, sample_code} * 13'd5;
	assign v = V_W'(prod >> SH);
	assign in_ready = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.ch <= func;
			item_s1.v <= v;
			item_s1.turb_zero <= (v >= V_4_2);
			item_s1.turb_full <= (v <= V_2_5);
		end
	end

endmodule

@@ rtl/core/wsa_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_queue
// Short item queue between the input stage and the sequencer.
// ----------------------------------------------------------------------------
module wsa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  wsa_pkg::item_t    wr_item,
	output logic              rd_valid,
	input  logic              rd_ready,
	output wsa_pkg::item_t    rd_item,
	output wsa_pkg::q_stat_t  stat
);
	import wsa_pkg::*;

	item_t mem_q [Q_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic push;
	logic pop;

	assign wr_ready = (count_q != Q_CW'(Q_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign stat.count = count_q;
	assign stat.empty = !rd_valid;
	assign stat.full = !wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

@@ rtl/core/wsa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_div
// Radix-2 signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module wsa_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [wsa_pkg::SUM_W-1:0] num,
	input  logic [wsa_pkg::DEN_W-1:0]        den,
	output logic                             done,
	output logic signed [wsa_pkg::SUM_W-1:0] quo
);
	import wsa_pkg::*;

	localparam int CW = $clog2(SUM_W);

	logic run_q;
	logic done_q;
	logic neg_q;
	logic [SUM_W-1:0] mag_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DEN_W:0] rem_sh;
	logic fits;

	assign rem_sh = {rem_q[DEN_W-1:0], mag_q[SUM_W-1]};
	assign fits = (rem_sh >= {1'b0, den_q});
	assign done = done_q;
	assign quo = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SUM_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[SUM_W-1];
			mag_q <= num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			mag_q <= {mag_q[SUM_W-2:0], fits};
		end
	end

endmodule

@@ rtl/core/wsa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_back
// Sequencer: channel formulas on a shared multiplier, per-channel averaging,
// alarm update and the output register.
// ----------------------------------------------------------------------------
module wsa_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  wsa_pkg::item_t                  item,
	input  wsa_pkg::cfg_t                   cfg,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wsa_pkg::chan_t                  channel,
	output logic signed [wsa_pkg::OUT_W-1:0] measured_value,
	output logic                            channel_alarm,
	output logic                            alarm_level,
	output logic                            notify
);
	import wsa_pkg::*;

	bk_state_t state_q, state_d;
	chan_t ch_q;
	logic [V_W-1:0] v_q;
	logic tz_q, tf_q;
	logic [2:0] step_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] v2_q, v3_q, cf_q, conv_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SUM_W-1:0] sums_q [4];
	logic [CNT_W-1:0] counts_q [4];
	logic signed [TEMP_W-1:0] temp_q;
	logic signed [OUT_W-1:0] avg_q;
	logic ph_al_q, tds_al_q, turb_al_q, comb_q;

	logic signed [31:0] vs, opa, opb;
	mul_dest_t dest;
	logic last;
	logic signed [ACC_W-1:0] qm;
	logic signed [ACC_W-1:0] tt, tr;
	logic signed [31:0] conv_v;
	logic signed [SUM_W:0] sum_x;
	logic signed [SUM_W-1:0] sum_sat;
	logic [CNT_W:0] cnt9;
	logic [CNT_W-1:0] target;
	logic done_cnt;
	logic div_start;
	logic signed [SUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic div_done;
	logic signed [SUM_W-1:0] div_quo;
	logic [SUM_W:0] mag;
	logic signed [SUM_W:0] avg_t;
	logic signed [OUT_W-1:0] avg_c;
	logic ph_n, tds_n, turb_n, now_n, ch_al_n;
	logic load_out;

	logic out_valid_q;
	chan_t out_ch_q;
	logic signed [OUT_W-1:0] out_val_q;
	logic out_cal_q, out_lvl_q, out_ntf_q;

	wsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign vs = $signed({21'b0, v_q});
	assign qm = ACC_W'((prod_q + 64'sd128) >>> FRAC_BITS);

	// multiplier program per channel
	always_comb begin
		opa = vs;
		opb = vs;
		dest = D_V2;
		last = 1'b1;
		case (ch_q)
			CH_PH: begin
				opa = K_5_7; dest = D_SUB;
			end
			CH_TDS: begin
				last = 1'b0;
				case (step_q)
					3'd0: begin opa = vs; opb = vs; dest = D_V2; end
					3'd1: begin opa = v2_q; opb = vs; dest = D_V3; end
					3'd2: begin opa = K_133_42; opb = v3_q; dest = D_ADD; end
					3'd3: begin opa = K_255_86; opb = v2_q; dest = D_SUB; end
					3'd4: begin opa = K_857_39; opb = vs; dest = D_ADD; end
					default: begin
						opa = K_0_02; opb = 32'(temp_q) - K_25; dest = D_CF; last = 1'b1;
					end
				endcase
			end
			CH_TURB: begin
				last = 1'b0;
				case (step_q)
					3'd0: begin opa = vs; opb = vs; dest = D_V2; end
					3'd1: begin opa = K_1120_4; opb = v2_q; dest = D_SUB; end
					default: begin opa = K_5742_3; opb = vs; dest = D_ADD; last = 1'b1; end
				endcase
			end
			default: ;
		endcase
	end

	// channel result and accumulate
	always_comb begin
		tt = acc_q - ACC_W'(K_4352_9);
		tr = ((tt + ACC_W'(128)) >>> FRAC_BITS) <<< FRAC_BITS;
		case (ch_q)
			CH_TEMP: conv_v = vs * 32'sd10;
			CH_PH: conv_v = K_21_34 + 32'(acc_q);
			CH_TURB: conv_v = tz_q ? 32'sd0 : (tf_q ? K_3000 : 32'(tr));
			default: conv_v = '0;
		endcase
		sum_x = (SUM_W+1)'(sums_q[ch_q]) + (SUM_W+1)'(conv_q);
		if (sum_x > (SUM_W+1)'(33'sh0_7fff_ffff)) sum_sat = 32'sh7fff_ffff;
		else if (sum_x < -(SUM_W+1)'(33'sh0_8000_0000)) sum_sat = 32'sh8000_0000;
		else sum_sat = SUM_W'(sum_x);
		target = (ch_q == CH_PH) ? cfg.ph_cnt : cfg.other_cnt;
		if (target == '0) target = CNT_W'(1);
		cnt9 = {1'b0, counts_q[ch_q]} + 1'b1;
		done_cnt = (cnt9 >= {1'b0, target});
	end

	// average finish and alarms
	always_comb begin
		mag = div_quo[SUM_W-1] ? -(SUM_W+1)'(div_quo) : (SUM_W+1)'(div_quo);
		if (ch_q == CH_TURB) mag[FRAC_BITS-1:0] = '0;
		avg_t = div_quo[SUM_W-1] ? -$signed(mag) : $signed(mag);
		if (avg_t > (SUM_W+1)'(24'sh7f_ffff)) avg_c = 24'sh7f_ffff;
		else if (avg_t < -(SUM_W+1)'(25'sh080_0000)) avg_c = 24'sh80_0000;
		else avg_c = OUT_W'(avg_t);
		ph_n = ph_al_q;
		tds_n = tds_al_q;
		turb_n = turb_al_q;
		ch_al_n = 1'b0;
		case (ch_q)
			CH_PH: begin
				ph_n = (avg_q < $signed({11'b0, cfg.ph_low})) ||
				       (avg_q > $signed({11'b0, cfg.ph_high}));
				ch_al_n = ph_n;
			end
			CH_TDS: begin
				tds_n = (avg_q > $signed({2'b0, cfg.tds_lim, 8'b0}));
				ch_al_n = tds_n;
			end
			CH_TURB: begin
				turb_n = ((avg_q >>> FRAC_BITS) > $signed({12'b0, cfg.turb_lim}));
				ch_al_n = turb_n;
			end
			default: ;
		endcase
		now_n = ph_n || tds_n || turb_n;
	end

	assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// next state and divider requests
	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		div_start = 1'b0;
		div_num = sum_sat;
		div_den = DEN_W'(cnt9);
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item.ch == CH_TEMP || (item.ch == CH_TURB &&
					    (item.turb_zero || item.turb_full)))
						state_d = ST_CONV;
					else
						state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_WB;
			ST_WB: state_d = last ? ST_CONV : ST_MUL;
			ST_CONV: begin
				if (ch_q == CH_TDS) begin
					div_start = 1'b1;
					div_num = SUM_W'((acc_q >>> 1) <<< FRAC_BITS);
					div_den = (cf_q < 32'sd1) ? DEN_W'(1) : DEN_W'(cf_q);
					state_d = ST_DIVW;
				end else begin
					state_d = ST_ACC;
				end
			end
			ST_DIVW: if (div_done) state_d = ST_ACC;
			ST_ACC: begin
				if (done_cnt) begin
					div_start = 1'b1;
					state_d = ST_AVGW;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_AVGW: if (div_done) state_d = ST_FIN;
			ST_FIN: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			for (int i = 0; i < 4; i++) begin
				sums_q[i] <= '0;
				counts_q[i] <= '0;
			end
			temp_q <= '0;
			ph_al_q <= 1'b0;
			tds_al_q <= 1'b0;
			turb_al_q <= 1'b0;
			comb_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) step_q <= '0;
			else if (state_q == ST_WB) step_q <= step_q + 1'b1;
			if (state_q == ST_ACC) begin
				if (done_cnt) begin
					sums_q[ch_q] <= '0;
					counts_q[ch_q] <= '0;
				end else begin
					sums_q[ch_q] <= sum_sat;
					counts_q[ch_q] <= CNT_W'(cnt9);
				end
			end
			if (state_q == ST_AVGW && div_done && ch_q == CH_TEMP) begin
				if (avg_c > 24'sd32767) temp_q <= 16'sh7fff;
				else if (avg_c < -24'sd32768) temp_q <= 16'sh8000;
				else temp_q <= TEMP_W'(avg_c);
			end
			if (load_out && ch_q != CH_TEMP) begin
				ph_al_q <= ph_n;
				tds_al_q <= tds_n;
				turb_al_q <= turb_n;
				comb_q <= now_n;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			ch_q <= item.ch;
			v_q <= item.v;
			tz_q <= item.turb_zero;
			tf_q <= item.turb_full;
			acc_q <= '0;
		end
		if (state_q == ST_MUL) prod_q <= opa * opb;
		if (state_q == ST_WB) begin
			case (dest)
				D_V2: v2_q <= 32'(qm);
				D_V3: v3_q <= 32'(qm);
				D_ADD: acc_q <= acc_q + qm;
				D_SUB: acc_q <= acc_q - qm;
				D_CF: cf_q <= K_ONE + 32'(qm);
				default: ;
			endcase
		end
		if (state_q == ST_CONV) conv_q <= conv_v;
		if (state_q == ST_DIVW && div_done) conv_q <= div_quo;
		if (state_q == ST_AVGW && div_done) avg_q <= avg_c;
		if (load_out) begin
			out_ch_q <= ch_q;
			out_val_q <= avg_q;
			out_cal_q <= ch_al_n;
			out_lvl_q <= (ch_q == CH_TEMP) ? comb_q : now_n;
			out_ntf_q <= (ch_q == CH_TEMP) ? 1'b0 : (now_n != comb_q);
		end
	end

	assign out_valid = out_valid_q;
	assign channel = out_ch_q;
	assign measured_value = out_val_q;
	assign channel_alarm = out_cal_q;
	assign alarm_level = out_lvl_q;
	assign notify = out_ntf_q;

endmodule

@@ rtl/core/water_sensor_average_alarm_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_sensor_average_alarm_core
// Per-channel sensor averaging with pH, TDS and turbidity alarms.
// ----------------------------------------------------------------------------
// timing: divisions (TDS compensation, average) and multiplier steps, each
//   a MUL then a WB state, dominate the time from sample to result
// flow: the single sequencer with one shared multiplier and one radix-2
//   divider takes an item only when idle; output stalls hold it in ST_FIN
// reset: arst_n clears sums, counts, alarms and handshakes; config to defaults
module water_sensor_average_alarm_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // sample_code, zero pad
	input  logic [1:0]                  s_axis_tuser,  // func
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// measured_value, channel_alarm, alarm_level, notify, zero pad
	output logic [31:0]                 m_axis_tdata,
	output logic [1:0]                  m_axis_tuser,  // channel
	input  logic                        cfg_we,
	input  logic [wsa_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [wsa_pkg::CFG_W-1:0]   cfg_wdata
);
	import wsa_pkg::*;

	cfg_t cfg_q;
	item_t fr_item, q_item;
	logic fr_valid, fr_ready, q_valid, q_ready;
	q_stat_t q_stat;
	chan_t out_ch;
	logic signed [OUT_W-1:0] out_val;
	logic out_cal, out_lvl, out_ntf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ph_cnt <= PH_CNT_RST;
			cfg_q.other_cnt <= OTHER_CNT_RST;
			cfg_q.ph_low <= PH_LOW_RST;
			cfg_q.ph_high <= PH_HIGH_RST;
			cfg_q.tds_lim <= TDS_LIM_RST;
			cfg_q.turb_lim <= TURB_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PH_CNT: cfg_q.ph_cnt <= cfg_wdata[7:0];
				REG_OTHER_CNT: cfg_q.other_cnt <= cfg_wdata[7:0];
				REG_PH_LOW: cfg_q.ph_low <= cfg_wdata[12:0];
				REG_PH_HIGH: cfg_q.ph_high <= cfg_wdata[12:0];
				REG_TDS_LIM: cfg_q.tds_lim <= cfg_wdata;
				REG_TURB_LIM: cfg_q.turb_lim <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	wsa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.func        (chan_t'(s_axis_tuser)),
		.sample_code (s_axis_tdata[9:0]),
		.item_valid  (fr_valid),
		.item_ready  (fr_ready),
		.item        (fr_item)
	);

	wsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_item  (fr_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item),
		.stat     (q_stat)
	);

	wsa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (q_valid),
		.item_ready     (q_ready),
		.item           (q_item),
		.cfg            (cfg_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.channel        (out_ch),
		.measured_value (out_val),
		.channel_alarm  (out_cal),
		.alarm_level    (out_lvl),
		.notify         (out_ntf)
	);

	assign m_axis_tuser = out_ch;
	assign m_axis_tdata = {5'b0, out_ntf, out_lvl, out_cal, out_val};

`include "assert_macros.svh"

	`ASSERT_NEVER(a_q_bound, clk, arst_n, q_stat.count > Q_CW'(Q_DEPTH), "queue overfilled")
	`ASSERT_CLK(a_q_flags, clk, arst_n, q_stat.empty == (q_stat.count == '0), "queue flag mismatch")
	`ASSERT_CLK(a_temp_quiet, clk, arst_n, (m_axis_tvalid && out_ch == CH_TEMP) |-> (!out_cal && !out_ntf), "temperature result raised alarm")

endmodule

@@ dv/tb_water_sensor_average_alarm_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_water_sensor_average_alarm_core
// Streams channel-tagged converter samples through the core under several
// register settings and random sender and receiver gaps. A fixed-point model
// in the bench predicts each averaged measurement and its alarm bits.
// ----------------------------------------------------------------------------
module tb_water_sensor_average_alarm_core;
	import wsa_pkg::*;

	typedef struct packed {
		chan_t     ch;
		logic [9:0] code;
	} sample_t;

	typedef struct packed {
		chan_t       ch;
		logic [23:0] value;
		logic        chan_alarm;
		logic        level;
		logic        notify;
	} meas_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;

	water_sensor_average_alarm_core dut (.*);

	// model state
	longint unsigned cnt_ph, cnt_other, lim_ph_lo, lim_ph_hi, lim_tds, lim_turb;
	longint sums[4];
	int unsigned counts[4];
	longint temp_q;
	bit alarm_ph, alarm_tds, alarm_turb, alarm_any;

	sample_t pending_q[$];
	meas_t meas_q[$];
	int errors = 0, n_in = 0, n_out = 0, n_alarm_flips = 0;
	bit in_fire, out_fire, gaps_on = 1, long_hold_req = 0, long_hold_done = 0;
	int tx_gap = 0, rx_hold = 0, idle_cycles = 0;

	function automatic longint qc(longint num, longint den);
		return (num * 2 * 256 + den) / (2 * den);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + 128) >>> 8;
	endfunction

	function automatic longint clampl(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint to_physical(chan_t ch, longint v);
		longint v2, v3, p, c, t;
		case (ch)
			CH_TEMP: return v * 10;
			CH_PH: return qc(2134, 100) - qmul(qc(57, 10), v);
			CH_TDS: begin
				v2 = qmul(v, v);
				v3 = qmul(v2, v);
				p = qmul(qc(13342, 100), v3) - qmul(qc(25586, 100), v2)
					+ qmul(qc(85739, 100), v);
				c = 256 + qmul(qc(2, 100), temp_q - 25 * 256);
				if (c < 1) c = 1;
				return ((p >>> 1) * 256) / c;
			end
			default: begin
				if (v >= qc(42, 10)) return 0;
				if (v <= qc(25, 10)) return 3000 * 256;
				t = -qmul(qc(11204, 10), qmul(v, v)) + qmul(qc(57423, 10), v)
					- qc(43529, 10);
				return ((t + 128) >>> 8) * 256;
			end
		endcase
	endfunction

	function automatic void predict_sample(sample_t s);
		longint v, avg;
		int unsigned target, n;
		bit now, ca;
		meas_t m;
		v = (longint'(s.code) * 5 * 256) >>> 10;
		target = int'((s.ch == CH_PH) ? cnt_ph : cnt_other);
		if (target == 0) target = 1;
		sums[s.ch] = clampl(sums[s.ch] + to_physical(s.ch, v), -64'sd2147483648,
			64'sd2147483647);
		n = counts[s.ch] + 1;
		if (n < target) begin
			counts[s.ch] = n;
			return;
		end
		avg = sums[s.ch] / longint'(n);
		sums[s.ch] = 0;
		counts[s.ch] = 0;
		if (s.ch == CH_TURB)
			avg = avg >= 0 ? ((avg >>> 8) <<< 8) : -(((-avg) >>> 8) <<< 8);
		avg = clampl(avg, -8388608, 8388607);
		ca = 0;
		now = alarm_any;
		if (s.ch == CH_TEMP) begin
			temp_q = clampl(avg, -32768, 32767);
		end else begin
			if (s.ch == CH_PH) begin
				alarm_ph = avg < longint'(lim_ph_lo) || avg > longint'(lim_ph_hi);
				ca = alarm_ph;
			end else if (s.ch == CH_TDS) begin
				alarm_tds = avg > longint'(lim_tds) * 256;
				ca = alarm_tds;
			end else begin
				alarm_turb = (avg >>> 8) > longint'(lim_turb);
				ca = alarm_turb;
			end
			now = alarm_ph || alarm_tds || alarm_turb;
		end
		m.ch = s.ch;
		m.value = avg[23:0];
		m.chan_alarm = ca;
		m.level = now;
		m.notify = now != alarm_any;
		alarm_any = now;
		meas_q.push_back(m);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// monitor: model update on input items, compare on output items
	always @(posedge clk) begin
		meas_t got, want;
		in_fire = s_axis_tvalid && s_axis_tready;
		out_fire = m_axis_tvalid && m_axis_tready;
		if (in_fire || out_fire || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (cfg_we) begin
			case (cfg_addr)
				REG_PH_CNT: cnt_ph = cfg_wdata[7:0];
				REG_OTHER_CNT: cnt_other = cfg_wdata[7:0];
				REG_PH_LOW: lim_ph_lo = cfg_wdata[12:0];
				REG_PH_HIGH: lim_ph_hi = cfg_wdata[12:0];
				REG_TDS_LIM: lim_tds = cfg_wdata[13:0];
				REG_TURB_LIM: lim_turb = cfg_wdata[11:0];
				default: ;
			endcase
		end
		if (in_fire) begin
			n_in++;
			predict_sample(sample_t'{chan_t'(s_axis_tuser), s_axis_tdata[9:0]});
		end
		if (out_fire) begin
			n_out++;
			got = meas_t'{chan_t'(m_axis_tuser), m_axis_tdata[23:0], m_axis_tdata[24],
				m_axis_tdata[25], m_axis_tdata[26]};
			if (meas_q.size() == 0) begin
				errors++;
				$display("%0t unexpected item: expected none, actual %p", $time, got);
			end else begin
				want = meas_q.pop_front();
				if (got.notify) n_alarm_flips++;
				if (got.ch !== want.ch || got.value !== want.value
					|| got.chan_alarm !== want.chan_alarm || got.level !== want.level
					|| got.notify !== want.notify) begin
					errors++;
					$display("%0t field mismatch: expected %p, actual %p", $time, want, got);
				end
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
		end else if (s_axis_tvalid && !in_fire) begin
			s_axis_tvalid <= 1;
		end else if (tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
			s_axis_tvalid <= 0;
		end else if (pending_q.size() > 0) begin
			s_axis_tdata <= {6'd0, pending_q[0].code};
			s_axis_tuser <= pending_q[0].ch;
			void'(pending_q.pop_front());
			s_axis_tvalid <= 1;
			tx_gap <= gaps_on ? $urandom_range(0, 10) : 0;
		end else begin
			s_axis_tvalid <= 0;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done <= 1;
			rx_hold <= 600;
			m_axis_tready <= 0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 0;
		end else if (out_fire && gaps_on) begin
			rx_hold <= $urandom_range(0, 10);
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > 5000) begin
			$display("timeout with %0d items outstanding", meas_q.size());
			$display("water_sensor_average_alarm_core: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// items without a result may still be in flight, so wait them out too
	task automatic drain();
		while (pending_q.size() > 0 || s_axis_tvalid || meas_q.size() > 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic push_sample(input chan_t ch, input int unsigned code);
		pending_q.push_back(sample_t'{ch, code[9:0]});
	endtask

	task automatic push_random(input int n);
		int unsigned r;
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r < 3) push_sample(CH_TURB, $urandom_range(500, 870));
			else push_sample(chan_t'($urandom_range(0, 3)), $urandom_range(0, 1023));
		end
	endtask

	task automatic set_regs(input int unsigned a, b, c, d, e, f);
		write_reg(REG_PH_CNT, a);
		write_reg(REG_OTHER_CNT, b);
		write_reg(REG_PH_LOW, c);
		write_reg(REG_PH_HIGH, d);
		write_reg(REG_TDS_LIM, e);
		write_reg(REG_TURB_LIM, f);
	endtask

	initial begin
		cnt_ph = 100; cnt_other = 5; lim_ph_lo = 1664; lim_ph_hi = 2176;
		lim_tds = 1000; lim_turb = 10;
		foreach (sums[i]) begin
			sums[i] = 0;
			counts[i] = 0;
		end
		temp_q = 0;
		{alarm_ph, alarm_tds, alarm_turb, alarm_any} = 0;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
		m_axis_tready = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// defaults: code extremes, turbidity band edges, partial sums carried on
		for (int c = 0; c < 4; c++) begin
			push_sample(chan_t'(c), 0);
			push_sample(chan_t'(c), 1023);
		end
		for (int k = 0; k < 5; k++) push_sample(CH_TEMP, 61 * (k + 1));
		push_sample(CH_TURB, 511); push_sample(CH_TURB, 512); push_sample(CH_TURB, 513);
		push_sample(CH_TURB, 859); push_sample(CH_TURB, 860); push_sample(CH_TURB, 700);
		push_sample(CH_TDS, 682); push_sample(CH_TDS, 341); push_sample(CH_TDS, 1);
		drain();

		// count of zero behaves as one, limits at zero
		gaps_on = 0;
		set_regs(0, 0, 0, 0, 0, 0);
		push_random(200);
		drain();

		// pH count of two, other count of one, limits at maximum
		gaps_on = 1;
		set_regs(2, 1, 8191, 8191, 16383, 4095);
		push_random(250);
		drain();

		// longest measurements
		set_regs(255, 255, 1000, 3000, 500, 2000);
		push_random(500);
		drain();

		// short counts under a long receiver stall, random limits
		set_regs(3, 2, $urandom_range(1200, 2000), $urandom_range(2000, 3000),
			$urandom_range(0, 3000), $urandom_range(0, 3000));
		long_hold_req = 1;
		push_random(450);
		drain();

		$display("%0d samples sent, %0d measurements checked, %0d alarm changes seen",
			n_in, n_out, n_alarm_flips);
		if (errors == 0) begin
			$display("water_sensor_average_alarm_core: match");
		end else begin
			$display("water_sensor_average_alarm_core: mismatch");
		end
		$finish;
	end

endmodule
